// ===== design/dtws_pkg.sv =====
// Package for the DDS tuning word serializer: shared constants, codes and
// control types. No dependencies.
`timescale 1ns / 1ps

package dtws_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned SCALE_W       = 48;
  localparam int unsigned SCALE_LO_W    = 24;
  localparam int unsigned SCALE_HI_W    = SCALE_W - SCALE_LO_W;
  localparam int unsigned PROD_W        = VALUE_W + SCALE_LO_W;
  localparam int unsigned FRAC_W        = 32;

  localparam int unsigned WORD_BITS_DEF   = 16;
  localparam int unsigned TUNING_BITS_DEF = 28;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 48'd15372286728;

  // Command codes
  localparam logic FUNC_CTRL = 1'b0;
  localparam logic FUNC_FREQ = 1'b1;

  // Register tags in the top two bits of a frequency frame
  localparam logic [1:0] TAG_REG0 = 2'b01;
  localparam logic [1:0] TAG_REG1 = 2'b10;

  // Shared multiplier operations
  typedef enum logic [1:0] {
    MOP_IDLE,
    MOP_LO,
    MOP_HI,
    MOP_SUM
  } mul_op_e;

  // Serializer load control
  typedef struct packed {
    logic load;
    logic two_frames;
    logic reset_first;
  } ser_ctrl_t;

endpackage

// ===== design/dtws_mul.sv =====
// Shared 32x24 multiplier with accumulator: forms value * scale over
// three steps. Depends on dtws_pkg.
`timescale 1ns / 1ps

module dtws_mul #(
  parameter int unsigned TUNING_BITS = dtws_pkg::TUNING_BITS_DEF
) (
  input  logic                             clk_i,
  input  dtws_pkg::mul_op_e                op_i,
  input  logic [dtws_pkg::VALUE_W-1:0]     value_i,
  input  logic [dtws_pkg::SCALE_W-1:0]     scale_i,
  output logic [TUNING_BITS-1:0]           tw_o
);

  localparam int unsigned ACC_W  = dtws_pkg::FRAC_W + TUNING_BITS;
  localparam int unsigned WIDE_W = dtws_pkg::PROD_W + ACC_W;

  logic [dtws_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic [ACC_W-1:0]                acc_q, acc_d;
  logic [dtws_pkg::SCALE_LO_W-1:0] mul_b;
  logic [WIDE_W-1:0]               prod_wide;
  logic [WIDE_W-1:0]               prod_shift;

  assign mul_b = (op_i == dtws_pkg::MOP_HI)
               ? scale_i[dtws_pkg::SCALE_W-1:dtws_pkg::SCALE_LO_W]
               : scale_i[dtws_pkg::SCALE_LO_W-1:0];

  assign prod_wide  = {{ACC_W{1'b0}}, prod_q};
  assign prod_shift = prod_wide << dtws_pkg::SCALE_LO_W;

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    case (op_i)
      dtws_pkg::MOP_LO: begin
        prod_d = value_i * mul_b;
      end
      dtws_pkg::MOP_HI: begin
        prod_d = value_i * mul_b;
        acc_d  = prod_wide[ACC_W-1:0];
      end
      dtws_pkg::MOP_SUM: begin
        acc_d = acc_q + prod_shift[ACC_W-1:0];
      end
      default: begin
        prod_d = prod_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // Drop the fraction, keep the low tuning bits
  assign tw_o = acc_q[ACC_W-1:dtws_pkg::FRAC_W];

endmodule

// ===== design/dtws_ser.sv =====
// Frame serializer: shifts one or two frames out MSB first, one bit per
// output word, through an output register. Depends on dtws_pkg.
`timescale 1ns / 1ps

module dtws_ser #(
  parameter int unsigned WORD_BITS = dtws_pkg::WORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dtws_pkg::ser_ctrl_t    ctrl_i,
  input  logic [2*WORD_BITS-1:0] data_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   serial_bit_o,
  output logic                   frame_start_o,
  output logic                   frame_end_o,
  output logic                   reset_pulse_o,
  output logic                   last_o
);

  localparam int unsigned SR_W = 2 * WORD_BITS;
  localparam int unsigned FC_W = $clog2(WORD_BITS);
  localparam logic [FC_W-1:0] FC_LAST = FC_W'(WORD_BITS - 1);

  logic [SR_W-1:0] sr_q, sr_d;
  logic [FC_W-1:0] fc_q, fc_d;
  logic            busy_q, busy_d;
  logic            second_q, second_d;
  logic            two_q, two_d;
  logic            rst_first_q, rst_first_d;
  logic            valid_q, valid_d;
  logic            advance;
  logic            at_start, at_end;

  assign advance  = busy_q && (!valid_q || out_ready_i);
  assign at_start = (fc_q == '0);
  assign at_end   = (fc_q == FC_LAST);

  always_comb begin
    sr_d        = sr_q;
    fc_d        = fc_q;
    busy_d      = busy_q;
    second_d    = second_q;
    two_d       = two_q;
    rst_first_d = rst_first_q;
    valid_d     = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (ctrl_i.load && !busy_q) begin
      sr_d        = data_i;
      fc_d        = '0;
      busy_d      = 1'b1;
      second_d    = 1'b0;
      two_d       = ctrl_i.two_frames;
      rst_first_d = ctrl_i.reset_first;
    end else if (advance) begin
      valid_d = 1'b1;
      sr_d    = {sr_q[SR_W-2:0], 1'b0};
      if (at_end) begin
        fc_d = '0;
        if (two_q && !second_q) begin
          second_d = 1'b1;
        end else begin
          busy_d = 1'b0;
        end
      end else begin
        fc_d = fc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      fc_q    <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      fc_q    <= fc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q        <= sr_d;
    second_q    <= second_d;
    two_q       <= two_d;
    rst_first_q <= rst_first_d;
    if (advance) begin
      serial_bit_o  <= sr_q[SR_W-1];
      frame_start_o <= at_start;
      frame_end_o   <= at_end;
      reset_pulse_o <= rst_first_q && at_start && !second_q;
      last_o        <= at_end && (second_q || !two_q);
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = valid_q;

endmodule

// ===== design/dds_tuning_word_serializer_unit.sv =====
// Top level of the DDS tuning word serializer: command sequencer, scale
// register, shared multiplier and frame serializer. Depends on dtws_pkg,
// dtws_mul and dtws_ser.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one command word: func_i,
//   freq_select_i, value_i. A control command (func 0) produces one frame of
//   WORD_BITS output words: the low WORD_BITS bits of value_i, MSB first, with
//   reset_pulse_o on the first. A frequency command (func 1) computes
//   tw = floor(value_i * scale / 2^32) mod 2^TUNING_BITS with the shared
//   32x24 multiplier (low partial, high partial, sum), then sends two tagged
//   frames, low half first: 2*WORD_BITS output words.
//   Output channel (out_valid_o/out_ready_i) carries one serial bit per word
//   with frame_start_o, frame_end_o and last_o marks.
//   Without a stall the serializer sends one bit per cycle.
//   in_ready_o stays low while a command is in flight; the last bit may still
//   wait in the output register while the next command is taken.
//   A stalled receiver holds the output word and freezes the shift register.
//   Reset clears the sequencer and output valid; the scale register returns
//   to the 75 MHz value. Write cfg_we_i/cfg_wdata_i only while idle.
`timescale 1ns / 1ps

module dds_tuning_word_serializer_unit #(
  parameter int unsigned WORD_BITS   = dtws_pkg::WORD_BITS_DEF,
  parameter int unsigned TUNING_BITS = dtws_pkg::TUNING_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dtws_pkg::SCALE_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic                          freq_select_i,
  input  logic [dtws_pkg::VALUE_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          serial_bit_o,
  output logic                          frame_start_o,
  output logic                          frame_end_o,
  output logic                          reset_pulse_o,
  output logic                          last_o
);

  localparam int unsigned HALF_BITS = WORD_BITS - 2;
  localparam int unsigned EXT_W     = TUNING_BITS + 2 * HALF_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_LOAD
  } state_e;

  state_e                         state_q, state_d;
  logic [dtws_pkg::SCALE_W-1:0]   scale_q;
  logic [dtws_pkg::VALUE_W-1:0]   value_q;
  logic                           func_q;
  logic                           sel_q;

  dtws_pkg::mul_op_e              mul_op;
  logic [TUNING_BITS-1:0]         tw;
  logic [EXT_W-1:0]               tw_ext;
  logic [HALF_BITS-1:0]           half_lo, half_hi;
  logic [1:0]                     tag;
  logic [2*WORD_BITS-1:0]         ser_data;
  dtws_pkg::ser_ctrl_t            ser_ctrl;
  logic                           ser_busy;
  logic                           in_fire;

  // Accept only with the sequencer idle and the shift register empty
  assign in_ready_o = (state_q == ST_IDLE) && !ser_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire) begin
        state_d = (func_i == dtws_pkg::FUNC_FREQ) ? ST_MUL_LO : ST_LOAD;
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_MUL_LO: mul_op = dtws_pkg::MOP_LO;
      ST_MUL_HI: mul_op = dtws_pkg::MOP_HI;
      ST_SUM:    mul_op = dtws_pkg::MOP_SUM;
      default:   mul_op = dtws_pkg::MOP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scale_q <= dtws_pkg::SCALE_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the command for the whole sequence
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      value_q <= value_i;
      func_q  <= func_i;
      sel_q   <= freq_select_i;
    end
  end

  dtws_mul #(
    .TUNING_BITS (TUNING_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .op_i    (mul_op),
    .value_i (value_q),
    .scale_i (scale_q),
    .tw_o    (tw)
  );

  // Split the tuning word into halves; bits past two halves drop
  assign tw_ext  = {{(2*HALF_BITS){1'b0}}, tw};
  assign half_lo = tw_ext[HALF_BITS-1:0];
  assign half_hi = tw_ext[2*HALF_BITS-1:HALF_BITS];
  assign tag     = sel_q ? dtws_pkg::TAG_REG1 : dtws_pkg::TAG_REG0;

  always_comb begin
    if (func_q == dtws_pkg::FUNC_FREQ) begin
      ser_data = {tag, half_lo, tag, half_hi};
    end else begin
      ser_data = {value_q[WORD_BITS-1:0], {WORD_BITS{1'b0}}};
    end
    ser_ctrl.load        = (state_q == ST_LOAD);
    ser_ctrl.two_frames  = (func_q == dtws_pkg::FUNC_FREQ);
    ser_ctrl.reset_first = (func_q == dtws_pkg::FUNC_CTRL);
  end

  dtws_ser #(
    .WORD_BITS (WORD_BITS)
  ) u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ser_ctrl),
    .data_i        (ser_data),
    .busy_o        (ser_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .serial_bit_o  (serial_bit_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o),
    .reset_pulse_o (reset_pulse_o),
    .last_o        (last_o)
  );

endmodule

// ===== tb/dtws_tb_pkg.sv =====
// Scoreboard for the DDS tuning word serializer testbench: predicts the serial
// words of each command and checks them in order. Depends on dtws_pkg.
`timescale 1ns / 1ps

package dtws_tb_pkg;

  import dtws_pkg::*;

  localparam int unsigned HALF_W = WORD_BITS_DEF - 2;

  typedef struct packed {
    logic serial_bit;
    logic frame_start;
    logic frame_end;
    logic reset_pulse;
    logic last;
  } dds_bit_t;

  class dds_bit_scoreboard;
    logic [SCALE_W-1:0] scale;
    dds_bit_t           pending_bits[$];
    int unsigned        fail_count;

    function new();
      scale      = SCALE_RESET;
      fail_count = 0;
    endfunction

    function void set_scale(logic [SCALE_W-1:0] s);
      scale = s;
    endfunction

    function int pending();
      return pending_bits.size();
    endfunction

    // Exact 80-bit product, drop 32 fraction bits, keep the low tuning bits.
    function logic [TUNING_BITS_DEF-1:0] tuning_word(logic [VALUE_W-1:0] freq);
      logic [VALUE_W+SCALE_W-1:0] prod;
      prod = {{SCALE_W{1'b0}}, freq} * {{VALUE_W{1'b0}}, scale};
      return prod[FRAC_W +: TUNING_BITS_DEF];
    endfunction

    function void push_frame(logic [WORD_BITS_DEF-1:0] frame, logic with_reset,
                             logic closes_command);
      dds_bit_t b;
      for (int i = 0; i < WORD_BITS_DEF; i++) begin
        b.serial_bit  = frame[WORD_BITS_DEF-1-i];
        b.frame_start = (i == 0);
        b.frame_end   = (i == WORD_BITS_DEF - 1);
        b.reset_pulse = with_reset && (i == 0);
        b.last        = closes_command && (i == WORD_BITS_DEF - 1);
        pending_bits.push_back(b);
      end
    endfunction

    function void note_command(logic func, logic sel, logic [VALUE_W-1:0] value);
      logic [TUNING_BITS_DEF-1:0] tw;
      logic [1:0]                 tag;
      if (func == FUNC_CTRL) begin
        push_frame(value[WORD_BITS_DEF-1:0], 1'b1, 1'b1);
      end else begin
        tw  = tuning_word(value);
        tag = sel ? TAG_REG1 : TAG_REG0;
        push_frame({tag, tw[HALF_W-1:0]}, 1'b0, 1'b0);
        push_frame({tag, tw[2*HALF_W-1:HALF_W]}, 1'b0, 1'b1);
      end
    endfunction

    function void check_bit(dds_bit_t got);
      dds_bit_t want;
      if (pending_bits.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: output word with nothing pending: ",
                    "bit=%b start=%b end=%b rst=%b last=%b"},
                   $time, got.serial_bit, got.frame_start, got.frame_end,
                   got.reset_pulse, got.last);
        return;
      end
      want = pending_bits.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: word mismatch bit %b/%b start %b/%b end %b/%b ",
                    "rst %b/%b last %b/%b (exp/act)"},
                   $time, want.serial_bit, got.serial_bit, want.frame_start,
                   got.frame_start, want.frame_end, got.frame_end,
                   want.reset_pulse, got.reset_pulse, want.last, got.last);
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top of the DDS tuning word serializer testbench: clock, reset, command and
// scale drivers, receiver stalls and word checking. Depends on dtws_pkg,
// dtws_tb_pkg and dds_tuning_word_serializer_unit.
`timescale 1ns / 1ps

module tb_top;

  import dtws_pkg::*;
  import dtws_tb_pkg::*;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [SCALE_W-1:0] cfg_wdata   = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               func        = FUNC_CTRL;
  logic               freq_select = 1'b0;
  logic [VALUE_W-1:0] value       = '0;
  logic               out_valid;
  logic               out_ready   = 1'b1;
  dds_bit_t           got;

  // Receiver idling and command gaps; cleared for the closing stretch.
  bit                 idle_on     = 1'b1;
  int                 stall_left  = 0;

  dds_bit_scoreboard  sb          = new();

  dds_tuning_word_serializer_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .freq_select_i (freq_select),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .serial_bit_o  (got.serial_bit),
    .frame_start_o (got.frame_start),
    .frame_end_o   (got.frame_end),
    .reset_pulse_o (got.reset_pulse),
    .last_o        (got.last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drop ready in bursts at random; long clean stretches
  // happen on their own between bursts. Cut any burst once idling ends.
  always @(negedge clk) begin
    if (!idle_on) begin
      out_ready  = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready  = 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(1, 12) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Check every word the receiver takes.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_bit(got);
  end

  // Offer one command; hold it until accepted. Starts and ends at a falling edge.
  task automatic send_command(input logic f, input logic sel, input logic [VALUE_W-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap      = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    func        = f;
    freq_select = sel;
    value       = v;
    do @(posedge clk); while (!in_ready);
    sb.note_command(f, sel, v);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait until every predicted word has left, then let the block settle.
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] s);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = s;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_scale(s);
  endtask

  // Random commands: mostly random frequencies and words, with a share of
  // the value extremes and of realistic output frequencies.
  task automatic run_random(input int count);
    logic [VALUE_W-1:0] v;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = '1;
        2:       v = $urandom_range(0, 1000);
        3:       v = $urandom_range(0, 37_500_000);
        default: v = $urandom;
      endcase
      send_command(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), v);
    end
  endtask

  initial begin
    logic [SCALE_W-1:0] scales[6];
    scales[0] = '1;
    scales[1] = '0;
    scales[2] = 48'h1_0000_0000;      // tuning word equals the frequency
    scales[3] = 48'd11529215046;      // 100 MHz master clock
    scales[4] = 48'({$urandom, $urandom});
    scales[5] = 48'd1;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part under the reset scale: control words at the extremes,
    // upper value bits and freq_select ignored, then frequency writes to
    // both registers, including tuning words that wrap past 28 bits.
    send_command(FUNC_CTRL, 1'b0, 32'h0000_0000);
    send_command(FUNC_CTRL, 1'b0, 32'h0000_FFFF);
    send_command(FUNC_CTRL, 1'b1, 32'h0000_8000);
    send_command(FUNC_CTRL, 1'b0, 32'hFFFF_FFFF);
    send_command(FUNC_CTRL, 1'b1, 32'hA5A5_5A5A);
    send_command(FUNC_CTRL, 1'b0, 32'h0000_0001);
    send_command(FUNC_FREQ, 1'b0, 32'h0000_0000);
    send_command(FUNC_FREQ, 1'b1, 32'h0000_0000);
    send_command(FUNC_FREQ, 1'b0, 32'h0000_0001);
    send_command(FUNC_FREQ, 1'b1, 32'hFFFF_FFFF);
    send_command(FUNC_FREQ, 1'b0, 32'hFFFF_FFFF);
    send_command(FUNC_FREQ, 1'b1, 32'd1_000_000);
    send_command(FUNC_FREQ, 1'b0, 32'd37_500_000);
    send_command(FUNC_FREQ, 1'b1, 32'h8000_0000);
    send_command(FUNC_FREQ, 1'b0, 32'd75_000_000);

    // Random phases, each under its own scale setting.
    foreach (scales[i]) begin
      write_scale(scales[i]);
      run_random(40);
    end

    // Closing stretch: reset scale written back, no idling on either side.
    write_scale(SCALE_RESET);
    idle_on = 1'b0;
    run_random(60);

    drain();
    repeat (40) @(negedge clk);
    if (sb.pending() == 0 && sb.fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
